// ===== hdl/ptt_pkg.sv =====
// ----------------------------------------------------------------------------
// ptt_pkg - shared types and constants for the triple tree generator
// Field widths, status codes, Berggren matrix selector and seed triple.
// ----------------------------------------------------------------------------
`default_nettype none

package ptt_pkg;

    localparam int DEF_STORE_DEPTH = 1024;
    localparam int DEF_NUM_WIDTH   = 32;

    // beat field widths
    localparam int IDX_W      = 10;
    localparam int SLOT_OUT_W = 10;
    localparam int LEG_W      = 32;
    localparam int STAT_W     = 2;
    localparam int S_TDATA_W  = 16;
    localparam int M_TDATA_W  = 112;
    localparam int M_PAD_W    = M_TDATA_W - SLOT_OUT_W - 3 * LEG_W;

    localparam int NEW_PER_EXPAND = 12;
    localparam int READ_ADVANCE   = 4;
    localparam int STEP_W         = $clog2(NEW_PER_EXPAND);

    localparam int SEED_A = 3;
    localparam int SEED_B = 4;
    localparam int SEED_C = 5;

    typedef enum logic {
        REQ_EXPAND = 1'b0,
        REQ_READ   = 1'b1
    } req_t;

    typedef enum logic [STAT_W-1:0] {
        STAT_OK         = 2'd0,
        STAT_FULL       = 2'd1,
        STAT_UNWRITTEN  = 2'd2
    } status_t;

    // A: (a,-b,c)  B: (a,b,c)  C: (-a,b,c), each through the common B form
    typedef enum logic [1:0] {
        BERG_A = 2'd0,
        BERG_B = 2'd1,
        BERG_C = 2'd2
    } berg_sel_t;

endpackage

`default_nettype wire

// ===== hdl/pythagorean_triple_tree_generator.sv =====
// ----------------------------------------------------------------------------
// pythagorean_triple_tree_generator - primitive Pythagorean triple store
// Expands the queued triple two Berggren levels deep, or reads a stored one.
//
//  channel | dir | tdata (low bit up)              | tuser     | tlast
//  s_      | in  | read_index, pad                 | req_type  | -
//  m_      | out | slot, leg_a, leg_b, hyp, pad    | status    | last
//
//  Expand: accept and fetch the parent, then twelve result beats, one a cycle
//  while the output does not stall, through the shared matrix unit and the
//  store's single write port. Read or refused expand: accept, then one result beat.
//  Output stalls hold the sequencer; a new request is taken while the last
//  result beat still waits. Synchronous reset, no clearing pass: slot 0 is
//  the fixed seed 3,4,5 and is never written.
// ----------------------------------------------------------------------------
`default_nettype none

module pythagorean_triple_tree_generator
    import ptt_pkg::*;
#(
    parameter int STORE_DEPTH = DEF_STORE_DEPTH,
    parameter int NUM_WIDTH   = DEF_NUM_WIDTH
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [S_TDATA_W-1:0]  s_tdata,   // read_index[9:0], pad
    input  wire logic                  s_tuser,   // req_type
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic      [M_TDATA_W-1:0]  m_tdata,   // slot, leg_a, leg_b, hyp, pad
    output logic      [STAT_W-1:0]     m_tuser,   // status
    output logic                       m_tlast
);

    localparam int ADDR_W = $clog2(STORE_DEPTH);
    localparam int SLOT_W = $clog2(STORE_DEPTH + 1);
    localparam int CMP_W  = (SLOT_W > IDX_W) ? SLOT_W : IDX_W;
    localparam int RAM_W  = 3 * NUM_WIDTH;
    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(NEW_PER_EXPAND - 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_REFUSE,
        ST_RUN
    } state_t;

    state_t             state_reg, state_next;
    logic [SLOT_W-1:0]  read_slot_reg, read_slot_next;
    logic [SLOT_W-1:0]  write_slot_reg, write_slot_next;
    logic [STEP_W-1:0]  step_reg, step_next;
    berg_sel_t          sel_reg, sel_next;
    logic [1:0]         grp_reg, grp_next;
    logic [IDX_W-1:0]   idx_reg, idx_next;
    logic               rd_ok_reg, rd_ok_next;
    logic               rd_zero_reg, rd_zero_next;
    logic [NUM_WIDTH-1:0] child_a_reg [3];
    logic [NUM_WIDTH-1:0] child_b_reg [3];
    logic [NUM_WIDTH-1:0] child_c_reg [3];
    logic [NUM_WIDTH-1:0] child_a_next [3];
    logic [NUM_WIDTH-1:0] child_b_next [3];
    logic [NUM_WIDTH-1:0] child_c_next [3];

    logic               m_valid_reg, m_valid_next;
    status_t            m_status_reg, m_status_next;
    logic [SLOT_OUT_W-1:0] m_slot_reg, m_slot_next;
    logic [LEG_W-1:0]   m_a_reg, m_a_next;
    logic [LEG_W-1:0]   m_b_reg, m_b_next;
    logic [LEG_W-1:0]   m_c_reg, m_c_next;
    logic               m_last_reg, m_last_next;

    logic               ram_we;
    logic               ram_re;
    logic [ADDR_W-1:0]  ram_raddr;
    logic [ADDR_W-1:0]  ram_waddr;
    logic [RAM_W-1:0]   ram_wdata;
    logic [RAM_W-1:0]   ram_rdata;

    logic [NUM_WIDTH-1:0] par_a, par_b, par_c;
    logic [NUM_WIDTH-1:0] src_a, src_b, src_c;
    logic [NUM_WIDTH-1:0] new_a, new_b, new_c;
    logic [1:0]           child_idx;
    logic [SLOT_W-1:0]    wr_slot;
    logic                 out_free;
    logic                 store_full;
    logic                 idx_ok;
    logic [IDX_W-1:0]     s_idx;
    req_t                 s_req;

    assign s_idx = s_tdata[IDX_W-1:0];
    assign s_req = req_t'(s_tuser);

    ptt_ram #(
        .WIDTH (RAM_W),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .clk   (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // slot 0 is the seed and lives outside the RAM
    always_comb begin
        if (rd_zero_reg) begin
            par_a = NUM_WIDTH'(SEED_A);
            par_b = NUM_WIDTH'(SEED_B);
            par_c = NUM_WIDTH'(SEED_C);
        end else begin
            par_a = ram_rdata[NUM_WIDTH-1:0];
            par_b = ram_rdata[2*NUM_WIDTH-1:NUM_WIDTH];
            par_c = ram_rdata[3*NUM_WIDTH-1:2*NUM_WIDTH];
        end
    end

    // first three steps work on the parent, then three on each child
    assign child_idx = grp_reg - 2'd1;
    always_comb begin
        if (grp_reg == 2'd0) begin
            src_a = par_a;
            src_b = par_b;
            src_c = par_c;
        end else begin
            src_a = child_a_reg[child_idx];
            src_b = child_b_reg[child_idx];
            src_c = child_c_reg[child_idx];
        end
    end

    ptt_berggren #(
        .W (NUM_WIDTH)
    ) u_berg (
        .sel   (sel_reg),
        .a_in  (src_a),
        .b_in  (src_b),
        .c_in  (src_c),
        .a_out (new_a),
        .b_out (new_b),
        .c_out (new_c)
    );

    assign out_free   = !m_valid_reg || m_tready;
    assign store_full = ({1'b0, write_slot_reg} + (SLOT_W+1)'(NEW_PER_EXPAND))
                        > (SLOT_W+1)'(STORE_DEPTH);
    assign idx_ok     = CMP_W'(s_idx) < CMP_W'(write_slot_reg);
    assign wr_slot    = write_slot_reg + SLOT_W'(step_reg);
    assign ram_waddr  = ADDR_W'(wr_slot);
    assign ram_wdata  = {new_c, new_b, new_a};
    assign s_tready   = (state_reg == ST_IDLE);

    always_comb begin
        state_next      = state_reg;
        read_slot_next  = read_slot_reg;
        write_slot_next = write_slot_reg;
        step_next       = step_reg;
        sel_next        = sel_reg;
        grp_next        = grp_reg;
        idx_next        = idx_reg;
        rd_ok_next      = rd_ok_reg;
        rd_zero_next    = rd_zero_reg;
        child_a_next    = child_a_reg;
        child_b_next    = child_b_reg;
        child_c_next    = child_c_reg;
        m_valid_next    = m_valid_reg && !m_tready;
        m_status_next   = m_status_reg;
        m_slot_next     = m_slot_reg;
        m_a_next        = m_a_reg;
        m_b_next        = m_b_reg;
        m_c_next        = m_c_reg;
        m_last_next     = m_last_reg;
        ram_we          = 1'b0;
        ram_re          = 1'b0;
        ram_raddr       = ADDR_W'(read_slot_reg);

        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    if (s_req == REQ_READ) begin
                        ram_re       = 1'b1;
                        ram_raddr    = ADDR_W'(s_idx);
                        idx_next     = s_idx;
                        rd_ok_next   = idx_ok;
                        rd_zero_next = (s_idx == '0);
                        state_next   = ST_READ;
                    end else if (store_full || read_slot_reg >= write_slot_reg) begin
                        state_next   = ST_REFUSE;
                    end else begin
                        ram_re       = 1'b1;
                        rd_zero_next = (read_slot_reg == '0);
                        step_next    = '0;
                        sel_next     = BERG_A;
                        grp_next     = 2'd0;
                        state_next   = ST_RUN;
                    end
                end
            end
            ST_READ: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_last_next  = 1'b1;
                    m_slot_next  = SLOT_OUT_W'(idx_reg);
                    if (rd_ok_reg) begin
                        m_status_next = STAT_OK;
                        m_a_next      = LEG_W'(par_a);
                        m_b_next      = LEG_W'(par_b);
                        m_c_next      = LEG_W'(par_c);
                    end else begin
                        m_status_next = STAT_UNWRITTEN;
                        m_a_next      = '0;
                        m_b_next      = '0;
                        m_c_next      = '0;
                    end
                    state_next = ST_IDLE;
                end
            end
            ST_REFUSE: begin
                if (out_free) begin
                    m_valid_next  = 1'b1;
                    m_last_next   = 1'b1;
                    m_status_next = STAT_FULL;
                    m_slot_next   = '0;
                    m_a_next      = '0;
                    m_b_next      = '0;
                    m_c_next      = '0;
                    state_next    = ST_IDLE;
                end
            end
            ST_RUN: begin
                if (out_free) begin
                    ram_we        = 1'b1;
                    m_valid_next  = 1'b1;
                    m_status_next = STAT_OK;
                    m_slot_next   = SLOT_OUT_W'(wr_slot);
                    m_a_next      = LEG_W'(new_a);
                    m_b_next      = LEG_W'(new_b);
                    m_c_next      = LEG_W'(new_c);
                    m_last_next   = (step_reg == LAST_STEP);
                    if (grp_reg == 2'd0) begin
                        child_a_next[sel_reg] = new_a;
                        child_b_next[sel_reg] = new_b;
                        child_c_next[sel_reg] = new_c;
                    end
                    unique case (sel_reg)
                        BERG_A:  sel_next = BERG_B;
                        BERG_B:  sel_next = BERG_C;
                        BERG_C:  sel_next = BERG_A;
                        default: sel_next = BERG_A;
                    endcase
                    if (sel_reg == BERG_C) begin
                        grp_next = grp_reg + 2'd1;
                    end
                    step_next = step_reg + 1'b1;
                    if (step_reg == LAST_STEP) begin
                        write_slot_next = write_slot_reg + SLOT_W'(NEW_PER_EXPAND);
                        read_slot_next  = read_slot_reg + SLOT_W'(READ_ADVANCE);
                        state_next      = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            read_slot_reg  <= '0;
            write_slot_reg <= SLOT_W'(1);
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            read_slot_reg  <= read_slot_next;
            write_slot_reg <= write_slot_next;
            m_valid_reg    <= m_valid_next;
        end
        step_reg      <= step_next;
        sel_reg       <= sel_next;
        grp_reg       <= grp_next;
        idx_reg       <= idx_next;
        rd_ok_reg     <= rd_ok_next;
        rd_zero_reg   <= rd_zero_next;
        child_a_reg   <= child_a_next;
        child_b_reg   <= child_b_next;
        child_c_reg   <= child_c_next;
        m_status_reg  <= m_status_next;
        m_slot_reg    <= m_slot_next;
        m_a_reg       <= m_a_next;
        m_b_reg       <= m_b_next;
        m_c_reg       <= m_c_next;
        m_last_reg    <= m_last_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_status_reg;
    assign m_tlast  = m_last_reg;
    assign m_tdata  = {{M_PAD_W{1'b0}}, m_c_reg, m_b_reg, m_a_reg, m_slot_reg};

`ifndef SYNTH
    a_queue_order: assert property (@(posedge aclk) disable iff (!aresetn)
        read_slot_reg < write_slot_reg)
        else $error("read slot caught up with write slot");

    a_store_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        write_slot_reg <= SLOT_W'(STORE_DEPTH))
        else $error("write slot beyond store");

    a_last_beat: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_RUN && out_free && step_reg == LAST_STEP)
        |=> (m_tvalid && m_tlast && state_reg == ST_IDLE))
        else $error("final expand beat without tlast");

    a_mid_beat: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_RUN && out_free && step_reg != LAST_STEP)
        |=> (m_tvalid && !m_tlast && state_reg == ST_RUN))
        else $error("early tlast or sequencer left expand");
`endif

endmodule

`default_nettype wire

// ===== hdl/ptt_ram.sv =====
// ----------------------------------------------------------------------------
// ptt_ram - generic single write port, single read port RAM
// Registered read; read data holds while read enable is low.
// ----------------------------------------------------------------------------
`default_nettype none

module ptt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// ===== hdl/ptt_berggren.sv =====
// ----------------------------------------------------------------------------
// ptt_berggren - shared Berggren matrix unit
// Applies matrix A, B or C to one triple, shifts and adds modulo 2^W.
// ----------------------------------------------------------------------------
`default_nettype none

module ptt_berggren
    import ptt_pkg::*;
#(
    parameter int W = DEF_NUM_WIDTH
) (
    input  wire berg_sel_t      sel,
    input  wire logic [W-1:0]   a_in,
    input  wire logic [W-1:0]   b_in,
    input  wire logic [W-1:0]   c_in,
    output logic      [W-1:0]   a_out,
    output logic      [W-1:0]   b_out,
    output logic      [W-1:0]   c_out
);

    logic [W-1:0] x;
    logic [W-1:0] y;
    logic [W-1:0] c2;

    always_comb begin
        unique case (sel)
            BERG_A: begin
                x = a_in;
                y = -b_in;
            end
            BERG_B: begin
                x = a_in;
                y = b_in;
            end
            BERG_C: begin
                x = -a_in;
                y = b_in;
            end
            default: begin
                x = a_in;
                y = b_in;
            end
        endcase
    end

    assign c2    = c_in << 1;
    assign a_out = x + (y << 1) + c2;
    assign b_out = (x << 1) + y + c2;
    assign c_out = (x << 1) + (y << 1) + c2 + c_in;

endmodule

`default_nettype wire
